// File: hdl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// property must hold at every clock outside reset
`define CHK_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("check failed");
// condition must never be true outside reset
`define CHK_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("forbidden condition seen");
`else
`define CHK_ASSERT(lbl, clk, rstn, prop)
`define CHK_NEVER(lbl, clk, rstn, cond)
`endif
`endif

// File: hdl/zsd_pkg.sv
`default_nettype none
package zsd_pkg;

  localparam int unsigned MAX_NAME_LEN = 4096;
  localparam logic [16:0] MAX_NAME_LEN_W = 17'(MAX_NAME_LEN);
  localparam logic [31:0] SIG_LOCAL = 32'h04034b50;
  localparam logic [15:0] ZIP64_ID = 16'h0001;
  localparam logic [63:0] SENT32 = 64'h0000_0000_FFFF_FFFF;
  localparam logic [15:0] HDR_LEN = 16'd26;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    KIND_NAME  = 3'd0,
    KIND_DATA  = 3'd1,
    KIND_ENTRY = 3'd2,
    KIND_DONE  = 3'd3,
    KIND_ERROR = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ERR_FORMAT = 2'd0,
    ERR_UNSUP  = 2'd1,
    ERR_TRUNC  = 2'd2
  } err_e;

  typedef enum logic [2:0] {
    PH_SIG   = 3'd0,
    PH_HDR   = 3'd1,
    PH_NAME  = 3'd2,
    PH_EXTRA = 3'd3,
    PH_DATA  = 3'd4,
    PH_HALT  = 3'd5
  } phase_e;

  typedef enum logic [2:0] {
    W_ID0  = 3'd0,
    W_ID1  = 3'd1,
    W_SZ0  = 3'd2,
    W_SZ1  = 3'd3,
    W_SKIP = 3'd4,
    W_Z64U = 3'd5,
    W_Z64C = 3'd6,
    W_DONE = 3'd7
  } walk_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data;
    logic [63:0] size;
    logic        dir;
    logic        lastb;
    logic [31:0] count;
    err_e        err;
  } res_t;

  // results caused by one input transfer
  typedef struct packed {
    logic two;
    res_t r0;
    res_t r1;
  } item_t;

  function automatic res_t mk_res(kind_e kind, logic [7:0] data, logic [63:0] size,
                                  logic dir, logic lastb, logic [31:0] count, err_e err);
    res_t r;
    r.kind  = kind;
    r.data  = data;
    r.size  = size;
    r.dir   = dir;
    r.lastb = lastb;
    r.count = count;
    r.err   = err;
    return r;
  endfunction

endpackage
`default_nettype wire

// File: hdl/zip_stored_entry_deframer.sv
// Stored-entry archive deframer.
// Input stream: one archive byte per transfer on s_axis_tdata[7:0]; a transfer
// with s_axis_tuser[0] set marks end of input and carries no byte.
// Output stream: one result per transfer, kind on m_axis_tuser; m_axis_tlast
// marks the last result caused by one input transfer (at most two results).
// Name bytes, an entry announcement with its size, data bytes (last one
// flagged), then a finish count or an error code close the archive. After
// finish or error all further input is taken and dropped until reset.
// Throughput: one input byte per cycle while the queue has room. The parser
// updates its state once per accepted byte; results go through a four-entry
// queue and an output register. The last name byte of an entry with no extra
// field gives two results, which leave the output one after the other; the
// queue absorbs that.
// When the receiver stalls, the queue fills and s_axis_tready drops once four
// entries are waiting. Reset returns the parser to waiting for a signature
// with a zero entry count and empties the queue.
`default_nettype none
module zip_stored_entry_deframer
  import zsd_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [7:0]   s_axis_tdata,  // in_byte
  input  wire logic [0:0]   s_axis_tuser,  // end_of_input
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // out_byte, entry_size, is_directory, last_data_byte, entry_count, error_code
  output logic [111:0]      m_axis_tdata,
  output logic [2:0]        m_axis_tuser,  // kind
  output logic              m_axis_tlast   // last_of_run
);

  logic  push, room, pop, not_empty;
  item_t push_item, head_item;
  res_t  res;

  zsd_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .byte_i  (s_axis_tdata),
    .eoi_i   (s_axis_tuser[0]),
    .room_i  (room),
    .ready_o (s_axis_tready),
    .push_o  (push),
    .item_o  (push_item)
  );

  zsd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .item_i      (push_item),
    .room_o      (room),
    .pop_i       (pop),
    .not_empty_o (not_empty),
    .head_o      (head_item)
  );

  zsd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .not_empty_i (not_empty),
    .item_i      (head_item),
    .pop_o       (pop),
    .ready_i     (m_axis_tready),
    .valid_o     (m_axis_tvalid),
    .res_o       (res),
    .last_o      (m_axis_tlast)
  );

  assign m_axis_tdata = {4'd0, res.err, res.count, res.lastb, res.dir, res.size, res.data};
  assign m_axis_tuser = res.kind;

endmodule
`default_nettype wire

// File: hdl/zsd_front.sv
`default_nettype none
module zsd_front
  import zsd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  input  wire logic [7:0]  byte_i,
  input  wire logic        eoi_i,
  input  wire logic        room_i,
  output logic             ready_o,
  output logic             push_o,
  output item_t            item_o
);

  phase_e      phase_q, phase_d;
  walk_e       walk_q, walk_d;
  logic [15:0] pos_q, pos_d;
  logic [63:0] asm_q, asm_d;
  logic        desc_q, desc_d;
  logic [15:0] method_q, method_d;
  logic [63:0] csize_q, csize_d;
  logic [63:0] usize_q, usize_d;
  logic [15:0] nlen_q, nlen_d;
  logic [15:0] xlen_q, xlen_d;
  logic [15:0] rid_q, rid_d;
  logic [15:0] rsize_q, rsize_d;
  logic        slash_q, slash_d;
  logic [63:0] remain_q, remain_d;
  logic [31:0] count_q, count_d;

  res_t r0, r1, rd;
  logic n0, n1, dec, dec_slot1;
  logic accept;

  assign ready_o = room_i;
  assign accept  = valid_i & room_i;

  // parse one byte and build its results
  always_comb begin
    phase_d  = phase_q;   walk_d  = walk_q;  pos_d   = pos_q;   asm_d    = asm_q;
    desc_d   = desc_q;    method_d = method_q; csize_d = csize_q; usize_d = usize_q;
    nlen_d   = nlen_q;    xlen_d  = xlen_q;  rid_d   = rid_q;   rsize_d  = rsize_q;
    slash_d  = slash_q;   remain_d = remain_q; count_d = count_q;
    r0 = '0; r1 = '0; rd = '0; n0 = 1'b0; n1 = 1'b0; dec = 1'b0; dec_slot1 = 1'b0;
    case (phase_q)
      PH_SIG: begin
        if (eoi_i) begin
          r0 = mk_res((pos_q == 16'd0) ? KIND_DONE : KIND_ERROR, 8'd0, 64'd0, 1'b0,
                      1'b0, count_q, ERR_FORMAT);
          n0 = 1'b1;
          phase_d = PH_HALT;
        end else begin
          if (pos_q == 16'd0) asm_d = '0;
          asm_d[8*pos_q[1:0] +: 8] = byte_i;
          pos_d = pos_q + 16'd1;
          if (pos_d >= 16'd4) begin
            pos_d = '0;
            if (asm_d == {32'd0, SIG_LOCAL}) begin
              phase_d = PH_HDR;
            end else begin
              r0 = mk_res(KIND_DONE, 8'd0, 64'd0, 1'b0, 1'b0, count_q, ERR_FORMAT);
              n0 = 1'b1;
              phase_d = PH_HALT;
            end
          end
        end
      end
      PH_HDR: begin
        if (eoi_i) begin
          r0 = mk_res(KIND_ERROR, 8'd0, 64'd0, 1'b0, 1'b0, count_q, ERR_FORMAT);
          n0 = 1'b1;
          phase_d = PH_HALT;
        end else begin
          case (pos_q)
            16'd2:  desc_d = byte_i[3];
            16'd4:  method_d = {8'd0, byte_i};
            16'd5:  method_d[15:8] = byte_i;
            16'd14: csize_d = {56'd0, byte_i};
            16'd15: csize_d[15:8] = byte_i;
            16'd16: csize_d[23:16] = byte_i;
            16'd17: csize_d[31:24] = byte_i;
            16'd18: usize_d = {56'd0, byte_i};
            16'd19: usize_d[15:8] = byte_i;
            16'd20: usize_d[23:16] = byte_i;
            16'd21: usize_d[31:24] = byte_i;
            16'd22: nlen_d = {8'd0, byte_i};
            16'd23: nlen_d[15:8] = byte_i;
            16'd24: xlen_d = {8'd0, byte_i};
            16'd25: xlen_d[15:8] = byte_i;
            default: ;
          endcase
          pos_d = pos_q + 16'd1;
          if (pos_d >= HDR_LEN) begin
            pos_d = '0;
            if (nlen_d == 16'd0 || {1'b0, nlen_d} >= MAX_NAME_LEN_W) begin
              r0 = mk_res(KIND_ERROR, 8'd0, 64'd0, 1'b0, 1'b0, count_q, ERR_FORMAT);
              n0 = 1'b1;
              phase_d = PH_HALT;
            end else begin
              slash_d = 1'b0;
              phase_d = PH_NAME;
            end
          end
        end
      end
      PH_NAME: begin
        if (eoi_i) begin
          r0 = mk_res(KIND_ERROR, 8'd0, 64'd0, 1'b0, 1'b0, count_q, ERR_FORMAT);
          n0 = 1'b1;
          phase_d = PH_HALT;
        end else begin
          r0 = mk_res(KIND_NAME, byte_i, 64'd0, 1'b0, 1'b0, 32'd0, ERR_FORMAT);
          n0 = 1'b1;
          slash_d = (byte_i == 8'h2F);
          pos_d = pos_q + 16'd1;
          if (pos_d >= nlen_q) begin
            pos_d = '0;
            if (xlen_q == 16'd0) begin
              dec = 1'b1;
              dec_slot1 = 1'b1;
            end else begin
              walk_d = W_ID0;
              phase_d = PH_EXTRA;
            end
          end
        end
      end
      PH_EXTRA: begin
        if (eoi_i) begin
          r0 = mk_res(KIND_ERROR, 8'd0, 64'd0, 1'b0, 1'b0, count_q, ERR_FORMAT);
          n0 = 1'b1;
          phase_d = PH_HALT;
        end else begin
          // extra field record walk
          case (walk_q)
            W_ID0: begin
              if (({1'b0, xlen_q} - {1'b0, pos_q}) < 17'd4) begin
                walk_d = W_DONE;
              end else begin
                rid_d = {8'd0, byte_i};
                walk_d = W_ID1;
              end
            end
            W_ID1: begin
              rid_d[15:8] = byte_i;
              walk_d = W_SZ0;
            end
            W_SZ0: begin
              rsize_d = {8'd0, byte_i};
              walk_d = W_SZ1;
            end
            W_SZ1: begin
              rsize_d = {byte_i, rsize_q[7:0]};
              if (({2'b0, pos_q} + 18'd1 + {2'b0, rsize_d}) > {2'b0, xlen_q}) begin
                walk_d = W_DONE;
              end else if (rid_q == ZIP64_ID) begin
                rid_d = '0;
                if (usize_q == SENT32 && rsize_d >= 16'd8) walk_d = W_Z64U;
                else if (csize_q == SENT32 && rsize_d >= 16'd8) walk_d = W_Z64C;
                else walk_d = W_DONE;
              end else if (rsize_d == 16'd0) begin
                walk_d = W_ID0;
              end else begin
                walk_d = W_SKIP;
              end
            end
            W_SKIP: begin
              rsize_d = rsize_q - 16'd1;
              if (rsize_d == 16'd0) walk_d = W_ID0;
            end
            W_Z64U, W_Z64C: begin
              asm_d = {byte_i, asm_q[63:8]};
              rid_d = rid_q + 16'd1;
              if (walk_q == W_Z64C) begin
                if (rid_d == 16'd8) begin
                  csize_d = asm_d;
                  walk_d = W_DONE;
                end
              end else if (rid_d == 16'd8) begin
                usize_d = asm_d;
                if (!(csize_q == SENT32 && rsize_q >= 16'd16)) walk_d = W_DONE;
              end else if (rid_d == 16'd16) begin
                csize_d = asm_d;
                walk_d = W_DONE;
              end
            end
            default: ;
          endcase
          pos_d = pos_q + 16'd1;
          if (pos_d >= xlen_q) dec = 1'b1;
        end
      end
      PH_DATA: begin
        if (eoi_i) begin
          r0 = mk_res(KIND_ERROR, 8'd0, 64'd0, 1'b0, 1'b0, count_q, ERR_TRUNC);
          n0 = 1'b1;
          phase_d = PH_HALT;
        end else begin
          remain_d = remain_q - 64'd1;
          r0 = mk_res(KIND_DATA, byte_i, 64'd0, 1'b0, remain_d == 64'd0, 32'd0,
                      ERR_FORMAT);
          n0 = 1'b1;
          if (remain_d == 64'd0) begin
            count_d = count_q + 32'd1;
            pos_d = '0;
            phase_d = PH_SIG;
          end
        end
      end
      default: ;
    endcase

    // entry decision after name or extra field
    if (dec) begin
      pos_d = '0;
      if (desc_d && csize_d == 64'd0) begin
        rd = mk_res(KIND_ERROR, 8'd0, 64'd0, 1'b0, 1'b0, count_q, ERR_UNSUP);
        phase_d = PH_HALT;
      end else if (method_d != 16'd0) begin
        rd = mk_res(KIND_ERROR, 8'd0, 64'd0, 1'b0, 1'b0, count_q, ERR_UNSUP);
        phase_d = PH_HALT;
      end else if (csize_d != usize_d) begin
        rd = mk_res(KIND_ERROR, 8'd0, 64'd0, 1'b0, 1'b0, count_q, ERR_FORMAT);
        phase_d = PH_HALT;
      end else begin
        rd = mk_res(KIND_ENTRY, 8'd0, usize_d, slash_d, 1'b0, 32'd0, ERR_FORMAT);
        if (slash_d || usize_d == 64'd0) begin
          count_d = count_q + 32'd1;
          phase_d = PH_SIG;
        end else begin
          remain_d = usize_d;
          phase_d = PH_DATA;
        end
      end
      if (dec_slot1) begin
        r1 = rd;
        n1 = 1'b1;
      end else begin
        r0 = rd;
        n0 = 1'b1;
      end
    end
  end

  assign push_o     = accept & n0;
  assign item_o.two = n1;
  assign item_o.r0  = r0;
  assign item_o.r1  = r1;

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SIG;   walk_q <= W_ID0;   pos_q <= '0;    asm_q <= '0;
      desc_q <= 1'b0;      method_q <= '0;    csize_q <= '0;  usize_q <= '0;
      nlen_q <= '0;        xlen_q <= '0;      rid_q <= '0;    rsize_q <= '0;
      slash_q <= 1'b0;     remain_q <= '0;    count_q <= '0;
    end else if (accept) begin
      phase_q <= phase_d;  walk_q <= walk_d;  pos_q <= pos_d;  asm_q <= asm_d;
      desc_q <= desc_d;    method_q <= method_d; csize_q <= csize_d; usize_q <= usize_d;
      nlen_q <= nlen_d;    xlen_q <= xlen_d;  rid_q <= rid_d;  rsize_q <= rsize_d;
      slash_q <= slash_d;  remain_q <= remain_d; count_q <= count_d;
    end
  end

endmodule
`default_nettype wire

// File: hdl/zsd_queue.sv
`default_nettype none
`include "assert_macros.svh"
module zsd_queue
  import zsd_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  item_t     item_i,
  output logic      room_o,
  input  wire logic pop_i,
  output logic      not_empty_o,
  output item_t     head_o
);

  item_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q;

  assign room_o      = cnt_q != QCNT_W'(QUEUE_DEPTH);
  assign not_empty_o = cnt_q != '0;
  assign head_o      = mem_q[rd_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i) rd_q <= rd_q + 1'b1;
      if (push_i && !pop_i) cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= item_i;
  end

  `CHK_NEVER(a_cnt_bound, clk_i, rst_ni, cnt_q > QCNT_W'(QUEUE_DEPTH))
  `CHK_ASSERT(a_pop_nonempty, clk_i, rst_ni, pop_i |-> cnt_q != '0)
  `CHK_ASSERT(a_push_grows, clk_i, rst_ni, (push_i && !pop_i) |=> cnt_q != '0)

endmodule
`default_nettype wire

// File: hdl/zsd_back.sv
`default_nettype none
`include "assert_macros.svh"
module zsd_back
  import zsd_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic not_empty_i,
  input  item_t     item_i,
  output logic      pop_o,
  input  wire logic ready_i,
  output logic      valid_o,
  output res_t      res_o,
  output logic      last_o
);

  logic sel_q, sel_d;
  logic mv_q, mv_d;
  res_t res_q;
  logic last_q;
  logic load;

  assign load = !mv_q || ready_i;

  // unpack one or two results per queue entry
  always_comb begin
    pop_o = 1'b0;
    sel_d = sel_q;
    mv_d  = mv_q;
    if (load) begin
      if (not_empty_i) begin
        mv_d = 1'b1;
        if (item_i.two && !sel_q) begin
          sel_d = 1'b1;
        end else begin
          sel_d = 1'b0;
          pop_o = 1'b1;
        end
      end else begin
        mv_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= 1'b0;
      mv_q  <= 1'b0;
    end else begin
      sel_q <= sel_d;
      mv_q  <= mv_d;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (load && not_empty_i) begin
      res_q  <= sel_q ? item_i.r1 : item_i.r0;
      last_q <= sel_q | !item_i.two;
    end
  end

  assign valid_o = mv_q;
  assign res_o   = res_q;
  assign last_o  = last_q;

  `CHK_NEVER(a_sel_needs_two, clk_i, rst_ni, sel_q && !(not_empty_i && item_i.two))
  `CHK_ASSERT(a_second_follows, clk_i, rst_ni, (load && sel_q) |-> pop_o)

endmodule
`default_nettype wire
